FILE: src/spmc_pkg.sv
package spmc_pkg;

    localparam logic [3:0] OP_WR_DATA = 4'd0;
    localparam logic [3:0] OP_RD_DATA = 4'd1;
    localparam logic [3:0] OP_WR_CTRL = 4'd2;
    localparam logic [3:0] OP_RD_STAT = 4'd3;
    localparam logic [3:0] OP_WR_MODE = 4'd4;
    localparam logic [3:0] OP_RD_MODE = 4'd5;
    localparam logic [3:0] OP_RD_CTRL = 4'd6;
    localparam logic [3:0] OP_WR_BAUD = 4'd7;
    localparam logic [3:0] OP_RD_BAUD = 4'd8;
    localparam logic [3:0] OP_IRQ_DUE = 4'd9;
    localparam logic [3:0] OP_PRELOAD = 4'd10;

    localparam logic [1:0] CFG_LINK_MODE   = 2'd0;
    localparam logic [1:0] CFG_IRQ_DISABLE = 2'd1;
    localparam logic [1:0] CFG_CARD_HEADER = 2'd2;

    localparam logic [15:0] ST_TX_RDY    = 16'h0001;
    localparam logic [15:0] ST_RX_RDY    = 16'h0002;
    localparam logic [15:0] ST_TX_EMPTY  = 16'h0004;
    localparam logic [15:0] ST_IRQ       = 16'h0200;
    localparam logic [15:0] CT_RESET_ERR = 16'h0010;
    localparam logic [15:0] CT_RESET     = 16'h0040;
    localparam logic [15:0] PORT_MASK    = 16'h2002;
    localparam logic [15:0] PORT_ONE     = 16'h0002;
    localparam logic [15:0] PORT_TWO     = 16'h2002;

    localparam logic [7:0] BUF_LEN     = 8'd134;
    localparam logic [7:0] FRAME_LEN   = 8'd128;
    localparam logic [7:0] PAD_START   = 8'h01;
    localparam logic [7:0] CARD_START  = 8'h81;
    localparam logic [7:0] CARD_READ   = 8'h52;
    localparam logic [7:0] CARD_WRITE  = 8'h57;
    localparam logic [7:0] FRAME_ID0   = 8'h5c;
    localparam logic [7:0] FRAME_ID1   = 8'h5d;
    localparam logic [7:0] FRAME_END   = 8'h47;
    localparam logic [7:0] PAD_ID_DIG  = 8'h41;
    localparam logic [7:0] PAD_CMD_43  = 8'h43;
    localparam logic [7:0] PAD_CMD_45  = 8'h45;
    localparam logic [7:0] PAD_ID_F3   = 8'hf3;

    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_READ  = 2'd1;
    localparam logic [1:0] DIR_WRITE = 2'd2;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [15:0] bus_value;
        logic [7:0]  pad_reply;
        logic        preload_card;
        logic [16:0] preload_address;
    } t_item;

    typedef struct packed {
        logic [15:0] read_data;
        logic        irq_schedule;
        logic        irq_cancel;
        logic        irq_raise;
    } t_result;

    typedef struct packed {
        logic        link_mode;
        logic        irq_disable;
        logic [31:0] card_header;
    } t_cfg;

    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_hs;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_PADB, S_RDWAIT,
        S_HDR, S_COPY, S_TAIL, S_COMMIT, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        HDR_START, HDR_READ, HDR_WRITE
    } t_hdr;

endpackage

FILE: src/spmc_ram.sv
module spmc_ram import spmc_pkg::*; #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/spmc_seq.sv
module spmc_seq import spmc_pkg::*; #(
    parameter int CARD_AW = 17
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    input  logic    i_out_free,
    output t_seq_hs o_hs,
    output t_result o_result
);

    localparam int FAW = CARD_AW - 7;
    localparam int MAW = CARD_AW + 1;
    localparam int MDEPTH = 2 * (1 << CARD_AW);

    t_state r_state, n_state;
    t_hdr   r_hdr, n_hdr;
    t_item  r_item, n_item;
    logic [7:0]     r_cnt, n_cnt;
    logic [MAW-1:0] r_clr, n_clr;
    logic [15:0] r_status, n_status, r_mode, n_mode, r_ctrl, n_ctrl, r_baud, n_baud;
    logic [7:0]  r_idx, n_idx, r_end, n_end, r_fh, n_fh, r_fl, n_fl, r_x, n_x;
    logic [1:0]  r_pph, n_pph, r_dir, n_dir;
    logic [2:0]  r_cph, n_cph;
    logic [15:0] r_rd, n_rd;
    logic r_sched, n_sched, r_cancel, n_cancel, r_raise, n_raise, r_oob, n_oob;

    logic           buf_we, card_we;
    logic [7:0]     buf_wa, buf_wd, buf_ra, buf_rd, card_wd, card_rd;
    logic [MAW-1:0] card_wa, card_ra;

    logic       w_port_ok, w_port, w_store;
    logic [7:0] w_v, w_ni, w_b, w_d, w_cm1;
    logic [15:0] w_fnum;
    logic [FAW-1:0] w_frame;
    logic [15:0] w_cw;

    spmc_ram #(.DEPTH(134), .AW(8)) u_buf (
        .i_clk(i_clk), .i_we(buf_we), .i_waddr(buf_wa), .i_wdata(buf_wd),
        .i_raddr(buf_ra), .o_rdata(buf_rd)
    );

    spmc_ram #(.DEPTH(MDEPTH), .AW(MAW)) u_card (
        .i_clk(i_clk), .i_we(card_we), .i_waddr(card_wa), .i_wdata(card_wd),
        .i_raddr(card_ra), .o_rdata(card_rd)
    );

    assign w_port_ok = ((r_ctrl & PORT_MASK) == PORT_ONE) || ((r_ctrl & PORT_MASK) == PORT_TWO);
    assign w_port    = r_ctrl[13];
    assign w_store   = !i_cfg.link_mode && w_port_ok;
    assign w_v       = r_item.bus_value[7:0];
    assign w_ni      = r_idx + 8'd1;
    assign w_fnum    = {r_fh, r_fl};
    assign w_frame   = w_fnum[FAW-1:0];
    assign w_b       = w_store ? r_item.pad_reply : buf_rd;
    assign w_d       = w_port_ok ? card_rd : buf_rd;
    assign w_cm1     = r_cnt - 8'd1;
    assign w_cw      = r_item.bus_value & ~CT_RESET_ERR;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (&r_clr) n_state = S_IDLE;
            S_IDLE:  if (i_start) n_state = S_EXEC;
            S_EXEC: begin
                n_state = S_DONE;
                if (r_item.opcode == OP_WR_DATA) begin
                    if (r_pph == 2'd1) begin
                        if (w_v[6]) n_state = S_PADB;
                    end else if (r_pph == 2'd0) begin
                        if (r_cph == 3'd4 && (r_dir == DIR_READ || r_dir == DIR_WRITE))
                            n_state = S_HDR;
                        if (r_cph == 3'd0 && w_v == CARD_START) n_state = S_HDR;
                    end
                end else if (r_item.opcode == OP_RD_DATA && r_status[1]) begin
                    n_state = S_RDWAIT;
                end
            end
            S_PADB: n_state = S_DONE;
            S_RDWAIT: begin
                n_state = S_DONE;
                if (r_idx == r_end && r_cph == 3'd5 && r_dir == DIR_WRITE && w_port_ok)
                    n_state = S_COMMIT;
            end
            S_HDR: begin
                if (r_hdr == HDR_WRITE) begin
                    if (r_cnt == 8'd4) n_state = S_DONE;
                end else if (r_cnt == 8'd3) begin
                    n_state = (r_hdr == HDR_READ) ? S_COPY : S_DONE;
                end
            end
            S_COPY:   if (r_cnt == FRAME_LEN) n_state = S_TAIL;
            S_TAIL:   if (r_cnt == 8'd1) n_state = S_DONE;
            S_COMMIT: if (r_cnt == FRAME_LEN) n_state = S_DONE;
            S_DONE:   if (i_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_hdr = r_hdr; n_item = r_item; n_cnt = r_cnt; n_clr = r_clr;
        n_status = r_status; n_mode = r_mode; n_ctrl = r_ctrl; n_baud = r_baud;
        n_idx = r_idx; n_end = r_end; n_fh = r_fh; n_fl = r_fl; n_x = r_x;
        n_pph = r_pph; n_dir = r_dir; n_cph = r_cph;
        n_rd = r_rd; n_sched = r_sched; n_cancel = r_cancel; n_raise = r_raise;
        n_oob = r_oob;
        buf_we = 1'b0; buf_wa = '0; buf_wd = '0; buf_ra = '0;
        card_we = 1'b0; card_wa = '0; card_wd = '0; card_ra = '0;
        case (r_state)
            S_CLEAR: begin
                card_we = 1'b1;
                card_wa = r_clr;
                if (r_clr < MAW'(BUF_LEN)) begin
                    buf_we = 1'b1;
                    buf_wa = r_clr[7:0];
                end
                n_clr = r_clr + MAW'(1);
            end
            S_IDLE: begin
                if (i_start) begin
                    n_item = i_item;
                    n_rd = '0; n_sched = 1'b0; n_cancel = 1'b0; n_raise = 1'b0;
                    n_cnt = '0;
                end
            end
            S_EXEC: begin
                case (r_item.opcode)
                    OP_WR_DATA: begin
                        if (r_pph == 2'd1) begin
                            n_sched = 1'b1;
                            if (w_v[6]) begin
                                n_pph = 2'd2;
                                n_idx = 8'd1;
                                buf_ra = 8'd1;
                                if (w_store) begin
                                    buf_we = 1'b1; buf_wa = 8'd1; buf_wd = r_item.pad_reply;
                                end
                            end else begin
                                n_pph = 2'd0;
                            end
                        end else if (r_pph == 2'd2) begin
                            n_idx = w_ni;
                            if (w_store && w_ni < BUF_LEN) begin
                                buf_we = 1'b1; buf_wa = w_ni; buf_wd = r_item.pad_reply;
                            end
                            if (w_ni == r_end) n_pph = 2'd0;
                            else n_sched = 1'b1;
                        end else begin
                            case (r_cph)
                                3'd1: begin
                                    n_sched = 1'b1;
                                    if (r_dir != DIR_NONE) begin
                                        n_idx = w_ni;
                                    end else begin
                                        n_idx = 8'd1;
                                        if (w_v == CARD_READ) n_dir = DIR_READ;
                                        else if (w_v == CARD_WRITE) n_dir = DIR_WRITE;
                                        else n_cph = 3'd0;
                                    end
                                end
                                3'd2: begin
                                    n_sched = 1'b1; n_fh = w_v;
                                    buf_we = 1'b1; buf_wa = 8'd0; buf_wd = 8'd0;
                                    n_idx = 8'd0; n_end = 8'd1; n_cph = 3'd3;
                                end
                                3'd3: begin
                                    n_sched = 1'b1; n_fl = w_v;
                                    buf_we = 1'b1; buf_wa = 8'd0; buf_wd = r_fh;
                                    n_idx = 8'd0; n_end = 8'd1; n_cph = 3'd4;
                                end
                                3'd4: begin
                                    n_sched = 1'b1; n_idx = 8'd0; n_cph = 3'd5;
                                    if (r_dir == DIR_READ) begin
                                        n_hdr = HDR_READ; n_x = r_fh ^ r_fl; n_end = 8'd133;
                                    end else if (r_dir == DIR_WRITE) begin
                                        n_hdr = HDR_WRITE; n_end = 8'd131;
                                    end
                                end
                                3'd5: begin
                                    n_idx = w_ni; n_sched = 1'b1;
                                    if (r_dir == DIR_WRITE && w_ni < FRAME_LEN) begin
                                        buf_we = 1'b1; buf_wa = w_ni + 8'd1; buf_wd = w_v;
                                    end
                                end
                                default: begin
                                    if (w_v == PAD_START) begin
                                        n_status = r_status | ST_RX_RDY;
                                        if (w_port_ok) begin
                                            buf_we = 1'b1; buf_wa = 8'd0; buf_wd = r_item.pad_reply;
                                        end
                                        n_end = 8'd2; n_idx = 8'd0; n_pph = 2'd1; n_sched = 1'b1;
                                    end else if (w_v == CARD_START) begin
                                        n_status = r_status | ST_RX_RDY;
                                        n_hdr = HDR_START;
                                        n_idx = 8'd0; n_end = 8'd3; n_cph = 3'd1;
                                        n_dir = DIR_NONE; n_sched = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                    OP_RD_DATA: begin
                        n_oob = (r_idx >= BUF_LEN);
                        buf_ra = (r_idx >= BUF_LEN) ? 8'd0 : r_idx;
                    end
                    OP_WR_CTRL: begin
                        n_ctrl = w_cw;
                        if (r_item.bus_value[4]) n_status = r_status & ~ST_IRQ;
                        if (w_cw[6] || w_cw == 16'd0) begin
                            n_pph = 2'd0; n_cph = 3'd0; n_idx = 8'd0;
                            n_status = ST_TX_RDY | ST_TX_EMPTY;
                            n_cancel = 1'b1;
                        end
                    end
                    OP_RD_STAT: n_rd = r_status;
                    OP_WR_MODE: n_mode = r_item.bus_value;
                    OP_RD_MODE: n_rd = r_mode;
                    OP_RD_CTRL: n_rd = r_ctrl;
                    OP_WR_BAUD: n_baud = r_item.bus_value;
                    OP_RD_BAUD: n_rd = r_baud;
                    OP_IRQ_DUE: begin
                        n_status = r_status | ST_IRQ; n_raise = 1'b1;
                    end
                    OP_PRELOAD: begin
                        card_we = 1'b1;
                        card_wa = {r_item.preload_card, r_item.preload_address[CARD_AW-1:0]};
                        card_wd = w_v;
                    end
                    default: ;
                endcase
            end
            S_PADB: begin
                n_end = (w_b[3:0] != 4'd0) ? 8'd2 + {3'd0, w_b[3:0], 1'b0} : 8'd34;
                if (w_b == PAD_ID_DIG && (w_v == PAD_CMD_43 || w_v == PAD_CMD_45)) begin
                    buf_we = 1'b1; buf_wa = 8'd1;
                    buf_wd = (w_v == PAD_CMD_43) ? PAD_CMD_43 : PAD_ID_F3;
                end
            end
            S_RDWAIT: begin
                n_rd = r_oob ? 16'd0 : {8'd0, buf_rd};
                if (r_idx == r_end) begin
                    n_status = r_status & ~ST_RX_RDY;
                    if (r_cph == 3'd5) n_cph = 3'd0;
                    if (r_pph == 2'd2) n_pph = 2'd0;
                    if (r_cph == 3'd1) begin
                        n_cph = 3'd2;
                        n_status = r_status | ST_RX_RDY;
                    end
                end
            end
            S_HDR: begin
                buf_we = 1'b1;
                n_cnt = r_cnt + 8'd1;
                case (r_hdr)
                    HDR_START: begin
                        buf_wa = r_cnt;
                        case (r_cnt[1:0])
                            2'd0:    buf_wd = i_cfg.card_header[31:24];
                            2'd1:    buf_wd = i_cfg.card_header[23:16];
                            2'd2:    buf_wd = i_cfg.card_header[15:8];
                            default: buf_wd = i_cfg.card_header[7:0];
                        endcase
                    end
                    HDR_READ: begin
                        buf_wa = r_cnt;
                        case (r_cnt[1:0])
                            2'd0:    buf_wd = FRAME_ID0;
                            2'd1:    buf_wd = FRAME_ID1;
                            2'd2:    buf_wd = r_fh;
                            default: buf_wd = r_fl;
                        endcase
                        if (r_cnt == 8'd3) n_cnt = 8'd0;
                    end
                    default: begin
                        case (r_cnt[2:0])
                            3'd0: begin buf_wa = 8'd0;   buf_wd = r_fl; end
                            3'd1: begin buf_wa = 8'd1;   buf_wd = w_v; end
                            3'd2: begin buf_wa = 8'd129; buf_wd = FRAME_ID0; end
                            3'd3: begin buf_wa = 8'd130; buf_wd = FRAME_ID1; end
                            default: begin buf_wa = 8'd131; buf_wd = FRAME_END; end
                        endcase
                    end
                endcase
            end
            S_COPY: begin
                n_cnt = r_cnt + 8'd1;
                if (r_cnt < FRAME_LEN) begin
                    card_ra = {w_port, w_frame, r_cnt[6:0]};
                    buf_ra = r_cnt + 8'd4;
                end
                if (r_cnt != 8'd0) begin
                    n_x = r_x ^ w_d;
                    if (w_port_ok) begin
                        buf_we = 1'b1; buf_wa = w_cm1 + 8'd4; buf_wd = w_d;
                    end
                end
                if (r_cnt == FRAME_LEN) n_cnt = 8'd0;
            end
            S_TAIL: begin
                buf_we = 1'b1;
                n_cnt = r_cnt + 8'd1;
                if (r_cnt == 8'd0) begin
                    buf_wa = 8'd132; buf_wd = r_x;
                end else begin
                    buf_wa = 8'd133; buf_wd = FRAME_END;
                end
            end
            S_COMMIT: begin
                n_cnt = r_cnt + 8'd1;
                if (r_cnt < FRAME_LEN) buf_ra = r_cnt + 8'd1;
                if (r_cnt != 8'd0) begin
                    card_we = 1'b1;
                    card_wa = {w_port, w_frame, w_cm1[6:0]};
                    card_wd = buf_rd;
                end
            end
            default: ;
        endcase
        if (r_state == S_RDWAIT && n_state == S_COMMIT) n_cnt = 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_status <= ST_TX_RDY | ST_TX_EMPTY;
            r_mode <= '0; r_ctrl <= '0; r_baud <= '0;
            r_idx <= '0; r_end <= '0; r_pph <= '0; r_cph <= '0; r_dir <= DIR_NONE;
            r_fh <= '0; r_fl <= '0;
            r_cnt <= '0; r_hdr <= HDR_START;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_status <= n_status;
            r_mode <= n_mode; r_ctrl <= n_ctrl; r_baud <= n_baud;
            r_idx <= n_idx; r_end <= n_end; r_pph <= n_pph; r_cph <= n_cph; r_dir <= n_dir;
            r_fh <= n_fh; r_fl <= n_fl;
            r_cnt <= n_cnt; r_hdr <= n_hdr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item; r_x <= n_x; r_oob <= n_oob;
        r_rd <= n_rd; r_sched <= n_sched; r_cancel <= n_cancel; r_raise <= n_raise;
    end

    assign o_hs.idle = (r_state == S_IDLE);
    assign o_hs.done = (r_state == S_DONE) && i_out_free;
    assign o_result.read_data    = r_rd;
    assign o_result.irq_schedule = r_sched && !i_cfg.irq_disable;
    assign o_result.irq_cancel   = r_cancel;
    assign o_result.irq_raise    = r_raise;

    a_clear_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> (r_state == S_CLEAR || r_state == S_IDLE))
        else $error("clear sweep left early");
    a_copy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY || r_state == S_COMMIT) |-> (r_cnt <= FRAME_LEN))
        else $error("frame counter overrun");
    a_phase_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pph != 2'd0) |-> (r_pph != 2'd3))
        else $error("bad pad phase");
    a_commit_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |-> (r_dir == DIR_WRITE && w_port_ok))
        else $error("commit without write frame");

endmodule

FILE: src/serial_pad_and_memory_card_port.sv
// Serial port controller for two pads and two memory cards.
// Input items arrive on s_axis: tuser is the bus opcode, tdata carries
// the write value, the pad byte and the preload target. Each item yields
// exactly one result item on m_axis: read data and the three interrupt
// flags.
// Work per item: register accesses and plain data writes run an execute
// step; a data read while data is ready adds a wait on the reply buffer,
// and a pad command byte adds a load of the reply length. A card start adds
// four header writes; the address byte of a card write frame adds five
// frame writes; the address byte of a card read frame adds four header
// writes, streams the frame out of card storage into the reply buffer and
// adds two trailer writes; the last data read of a card write frame, with a
// port selected, copies 128 bytes into card storage. Each memory has one
// write port and one read port. The next item is taken from the cycle after a result is loaded.
// After reset the block sweeps both card images and the reply buffer to
// zero, one byte per cycle, with s_axis_tready low; configuration writes
// are taken during the sweep.
// A finished result sits in the output register; the next item is taken
// while it waits, and its own result stalls until m_axis_tready.
module serial_pad_and_memory_card_port import spmc_pkg::*; #(
    parameter int CARD_AW = 17
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // bus_value[15:0], pad_reply[23:16], preload_card[24], preload_address[41:25]
    input  logic [47:0] s_axis_tdata,
    // opcode[3:0]
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[15:0], irq_schedule[16], irq_cancel[17], irq_raise[18]
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_item   w_item;
    t_result w_res;
    t_seq_hs w_hs;
    logic    r_m_valid;
    logic [23:0] r_m_data;
    logic    w_free;

    assign w_item.opcode          = s_axis_tuser;
    assign w_item.bus_value       = s_axis_tdata[15:0];
    assign w_item.pad_reply       = s_axis_tdata[23:16];
    assign w_item.preload_card    = s_axis_tdata[24];
    assign w_item.preload_address = s_axis_tdata[41:25];

    assign w_free = !r_m_valid || m_axis_tready;
    assign s_axis_tready = w_hs.idle;

    spmc_seq #(.CARD_AW(CARD_AW)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(s_axis_tvalid && s_axis_tready),
        .i_item(w_item), .i_cfg(r_cfg), .i_out_free(w_free),
        .o_hs(w_hs), .o_result(w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{link_mode: 1'b0, irq_disable: 1'b0, card_header: 32'hFF085A5D};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINK_MODE:   r_cfg.link_mode   <= i_cfg_data[0];
                CFG_IRQ_DISABLE: r_cfg.irq_disable <= i_cfg_data[0];
                CFG_CARD_HEADER: r_cfg.card_header <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_hs.done) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hs.done) begin
            r_m_data <= {5'd0, w_res.irq_raise, w_res.irq_cancel, w_res.irq_schedule,
                         w_res.read_data};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item taken while busy");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hs.done |-> (!r_m_valid || m_axis_tready))
        else $error("result overwrote a waiting item");
    a_raise_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_m_data[18]) |-> (r_m_data[15:0] == 16'd0 && !r_m_data[17]))
        else $error("raise mixed with other result fields");

endmodule

FILE: tb/tb_serial_pad_and_memory_card_port.sv
`timescale 1ns / 1ps

module tb_serial_pad_and_memory_card_port import spmc_pkg::*;;

    localparam int CARD_SIZE  = 131072;
    localparam int NUM_ITEMS  = 950;
    localparam int SETTLE     = 220;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [3:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    serial_pad_and_memory_card_port u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // shadow of the port controller
    logic        sh_link_mode;
    logic        sh_irq_disable;
    logic [31:0] sh_header;
    logic [15:0] sh_status, sh_mode, sh_ctrl, sh_baud;
    logic [7:0]  sh_reply [0:133];
    logic [7:0]  sh_idx, sh_end;
    logic [1:0]  sh_pad_phase;
    logic [2:0]  sh_card_phase;
    logic [1:0]  sh_dir;
    logic [7:0]  sh_frame_hi, sh_frame_lo;
    logic [7:0]  sh_card [0:2*CARD_SIZE-1];
    logic        sh_sched;

    t_result     due_results [$];
    t_item       stim_q [$];
    int          error_count;
    int          results_seen;
    int          items_sent;
    bit          burst;

    function automatic int sel_port();
        if ((sh_ctrl & PORT_MASK) == PORT_ONE) return 0;
        if ((sh_ctrl & PORT_MASK) == PORT_TWO) return 1;
        return -1;
    endfunction

    function automatic int frame_addr(int card);
        logic [15:0] f;
        f = {sh_frame_hi, sh_frame_lo};
        return card * CARD_SIZE + int'(f[9:0]) * 128;
    endfunction

    function automatic void put_reply(logic [7:0] i, logic [7:0] v);
        if (i < BUF_LEN) sh_reply[i] = v;
    endfunction

    function automatic void want_irq();
        if (!sh_irq_disable) sh_sched = 1'b1;
    endfunction

    function automatic void pad_capture(logic [7:0] pad);
        if (!sh_link_mode && sel_port() >= 0) put_reply(sh_idx, pad);
    endfunction

    function automatic void data_write(logic [7:0] v, logic [7:0] pad);
        logic [7:0] b;
        logic [7:0] x;
        int         base;
        int         card;
        if (sh_pad_phase == 2'd1) begin
            want_irq();
            if (v[6]) begin
                sh_pad_phase = 2'd2;
                sh_idx = 8'd1;
                pad_capture(pad);
                b = sh_reply[1];
                sh_end = (b[3:0] != 0) ? 8'(2 + b[3:0] * 2) : 8'd34;
                if (b == PAD_ID_DIG) begin
                    if (v == PAD_CMD_43) sh_reply[1] = PAD_CMD_43;
                    else if (v == PAD_CMD_45) sh_reply[1] = PAD_ID_F3;
                end
            end else begin
                sh_pad_phase = 2'd0;
            end
            return;
        end
        if (sh_pad_phase == 2'd2) begin
            sh_idx = sh_idx + 8'd1;
            pad_capture(pad);
            if (sh_idx == sh_end) begin
                sh_pad_phase = 2'd0;
                return;
            end
            want_irq();
            return;
        end
        case (sh_card_phase)
            3'd1: begin
                want_irq();
                if (sh_dir != DIR_NONE) begin
                    sh_idx = sh_idx + 8'd1;
                    return;
                end
                sh_idx = 8'd1;
                if (v == CARD_READ) sh_dir = DIR_READ;
                else if (v == CARD_WRITE) sh_dir = DIR_WRITE;
                else sh_card_phase = 3'd0;
                return;
            end
            3'd2: begin
                want_irq();
                sh_frame_hi = v;
                sh_reply[0] = 8'd0;
                sh_idx = 8'd0;
                sh_end = 8'd1;
                sh_card_phase = 3'd3;
                return;
            end
            3'd3: begin
                want_irq();
                sh_frame_lo = v;
                sh_reply[0] = sh_frame_hi;
                sh_idx = 8'd0;
                sh_end = 8'd1;
                sh_card_phase = 3'd4;
                return;
            end
            3'd4: begin
                want_irq();
                sh_idx = 8'd0;
                if (sh_dir == DIR_READ) begin
                    sh_reply[0] = FRAME_ID0;
                    sh_reply[1] = FRAME_ID1;
                    sh_reply[2] = sh_frame_hi;
                    sh_reply[3] = sh_frame_lo;
                    card = sel_port();
                    if (card >= 0) begin
                        base = frame_addr(card);
                        for (int k = 0; k < 128; k++) sh_reply[4 + k] = sh_card[base + k];
                    end
                    x = 8'd0;
                    for (int k = 2; k < 132; k++) x ^= sh_reply[k];
                    sh_reply[132] = x;
                    sh_reply[133] = FRAME_END;
                    sh_end = 8'd133;
                end else if (sh_dir == DIR_WRITE) begin
                    sh_reply[0] = sh_frame_lo;
                    sh_reply[1] = v;
                    sh_reply[129] = FRAME_ID0;
                    sh_reply[130] = FRAME_ID1;
                    sh_reply[131] = FRAME_END;
                    sh_end = 8'd131;
                end
                sh_card_phase = 3'd5;
                return;
            end
            3'd5: begin
                sh_idx = sh_idx + 8'd1;
                if (sh_dir == DIR_WRITE && sh_idx < FRAME_LEN) put_reply(sh_idx + 8'd1, v);
                want_irq();
                return;
            end
            default: ;
        endcase
        if (v == PAD_START) begin
            sh_status |= ST_RX_RDY;
            if (sel_port() >= 0) sh_reply[0] = pad;
            sh_end = 8'd2;
            sh_idx = 8'd0;
            sh_pad_phase = 2'd1;
            want_irq();
        end else if (v == CARD_START) begin
            sh_status |= ST_RX_RDY;
            sh_reply[0] = sh_header[31:24];
            sh_reply[1] = sh_header[23:16];
            sh_reply[2] = sh_header[15:8];
            sh_reply[3] = sh_header[7:0];
            sh_idx = 8'd0;
            sh_end = 8'd3;
            sh_card_phase = 3'd1;
            sh_dir = DIR_NONE;
            want_irq();
        end
    endfunction

    function automatic logic [7:0] data_read();
        logic [7:0] r;
        int         card;
        int         base;
        if (!(sh_status & ST_RX_RDY)) return 8'd0;
        r = (sh_idx < BUF_LEN) ? sh_reply[sh_idx] : 8'd0;
        if (sh_idx == sh_end) begin
            sh_status &= ~ST_RX_RDY;
            if (sh_card_phase == 3'd5) begin
                sh_card_phase = 3'd0;
                card = sel_port();
                if (sh_dir == DIR_WRITE && card >= 0) begin
                    base = frame_addr(card);
                    for (int k = 0; k < 128; k++) sh_card[base + k] = sh_reply[1 + k];
                end
            end
            if (sh_pad_phase == 2'd2) sh_pad_phase = 2'd0;
            if (sh_card_phase == 3'd1) begin
                sh_card_phase = 3'd2;
                sh_status |= ST_RX_RDY;
            end
        end
        return r;
    endfunction

    function automatic t_result port_predict(t_item it);
        t_result res;
        res = '0;
        sh_sched = 1'b0;
        case (it.opcode)
            OP_WR_DATA: data_write(it.bus_value[7:0], it.pad_reply);
            OP_RD_DATA: res.read_data = {8'd0, data_read()};
            OP_WR_CTRL: begin
                sh_ctrl = it.bus_value & ~CT_RESET_ERR;
                if (it.bus_value & CT_RESET_ERR) sh_status &= ~ST_IRQ;
                if ((sh_ctrl & CT_RESET) != 0 || sh_ctrl == 16'd0) begin
                    sh_pad_phase = 2'd0;
                    sh_card_phase = 3'd0;
                    sh_idx = 8'd0;
                    sh_status = ST_TX_RDY | ST_TX_EMPTY;
                    res.irq_cancel = 1'b1;
                end
            end
            OP_RD_STAT: res.read_data = sh_status;
            OP_WR_MODE: sh_mode = it.bus_value;
            OP_RD_MODE: res.read_data = sh_mode;
            OP_RD_CTRL: res.read_data = sh_ctrl;
            OP_WR_BAUD: sh_baud = it.bus_value;
            OP_RD_BAUD: res.read_data = sh_baud;
            OP_IRQ_DUE: begin
                sh_status |= ST_IRQ;
                res.irq_raise = 1'b1;
            end
            OP_PRELOAD: sh_card[int'(it.preload_card) * CARD_SIZE + int'(it.preload_address)]
                = it.bus_value[7:0];
            default: ;
        endcase
        res.irq_schedule = sh_sched;
        return res;
    endfunction

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
        error_count++;
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_LINK_MODE:   sh_link_mode = val[0];
            CFG_IRQ_DISABLE: sh_irq_disable = val[0];
            default:         sh_header = val;
        endcase
    endtask

    task automatic apply_cfg(logic lm, logic dis, logic [31:0] hdr);
        cfg_write(CFG_LINK_MODE, {31'd0, lm});
        cfg_write(CFG_IRQ_DISABLE, {31'd0, dis});
        cfg_write(CFG_CARD_HEADER, hdr);
        i_cfg_we <= 1'b0;
    endtask

    // called right after a rising edge; leaves the item accepted at the last edge
    task automatic send_item(t_item it, bit typed, t_result want);
        int      gap;
        t_result got_pred;
        if ($urandom_range(0, 31) == 0) burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.opcode;
        s_axis_tdata  <= {6'd0, it.preload_address, it.preload_card, it.pad_reply,
                          it.bus_value};
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        got_pred = port_predict(it);
        due_results.push_back(typed ? want : got_pred);
        items_sent++;
    endtask

    task automatic drain();
        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_item mk(logic [3:0] op, logic [15:0] bv);
        t_item it;
        it.opcode          = op;
        it.bus_value       = bv;
        it.pad_reply       = 8'($urandom_range(0, 255));
        it.preload_card    = 1'($urandom_range(0, 1));
        it.preload_address = 17'($urandom_range(0, CARD_SIZE - 1));
        return it;
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom_range(0, 65535)) & ~CT_RESET;
            1, 2, 3, 4: return PORT_TWO;
            default: return PORT_ONE;
        endcase
    endfunction

    function automatic void gen_pad();
        t_item it;
        int    n;
        stim_q.push_back(mk(OP_WR_CTRL, pick_port()));
        it = mk(OP_WR_DATA, {8'($urandom), PAD_START});
        if ($urandom_range(0, 1)) it.pad_reply = PAD_ID_DIG;
        stim_q.push_back(it);
        stim_q.push_back(mk(OP_RD_DATA, 16'($urandom)));
        case ($urandom_range(0, 4))
            0: stim_q.push_back(mk(OP_WR_DATA, {8'd0, PAD_CMD_43}));
            1: stim_q.push_back(mk(OP_WR_DATA, {8'd0, PAD_CMD_45}));
            2: stim_q.push_back(mk(OP_WR_DATA, 16'($urandom)));
            default: stim_q.push_back(mk(OP_WR_DATA, 16'h0042));
        endcase
        n = $urandom_range(0, 24);
        for (int k = 0; k < n; k++) begin
            stim_q.push_back(mk(OP_RD_DATA, 16'($urandom)));
            stim_q.push_back(mk(OP_WR_DATA, 16'($urandom)));
        end
        stim_q.push_back(mk(OP_RD_DATA, 16'($urandom)));
        stim_q.push_back(mk(OP_RD_STAT, 16'($urandom)));
    endfunction

    function automatic void gen_card();
        logic [7:0]  hi, lo, cmd;
        logic [15:0] port;
        int          n;
        int          base;
        t_item       it;
        case ($urandom_range(0, 3))
            0: hi = 8'h00;
            1: hi = 8'hff;
            default: hi = 8'($urandom_range(0, 3));
        endcase
        case ($urandom_range(0, 3))
            0: lo = 8'h00;
            1: lo = 8'hff;
            default: lo = 8'($urandom_range(0, 3));
        endcase
        cmd = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
              ($urandom_range(0, 1) ? CARD_READ : CARD_WRITE);
        port = pick_port();
        base = int'({hi, lo} & 16'h03ff) * 128;
        n = $urandom_range(0, 6);
        for (int k = 0; k < n; k++) begin
            it = mk(OP_PRELOAD, 16'($urandom));
            it.preload_card = port[13];
            it.preload_address = 17'(base + $urandom_range(0, 127));
            stim_q.push_back(it);
        end
        stim_q.push_back(mk(OP_WR_CTRL, port));
        stim_q.push_back(mk(OP_WR_DATA, {8'($urandom), CARD_START}));
        stim_q.push_back(mk(OP_RD_DATA, 16'($urandom)));
        stim_q.push_back(mk(OP_WR_DATA, {8'($urandom), cmd}));
        stim_q.push_back(mk(OP_WR_DATA, 16'($urandom)));
        stim_q.push_back(mk(OP_WR_DATA, 16'($urandom)));
        stim_q.push_back(mk(OP_RD_DATA, 16'($urandom)));
        stim_q.push_back(mk(OP_WR_DATA, {8'($urandom), hi}));
        stim_q.push_back(mk(OP_RD_DATA, 16'($urandom)));
        stim_q.push_back(mk(OP_WR_DATA, {8'($urandom), lo}));
        stim_q.push_back(mk(OP_RD_DATA, 16'($urandom)));
        stim_q.push_back(mk(OP_WR_DATA, 16'($urandom)));
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 140) : 131 + 2 * (cmd == CARD_READ);
        for (int k = 0; k < n; k++) begin
            stim_q.push_back(mk(OP_RD_DATA, 16'($urandom)));
            stim_q.push_back(mk(OP_WR_DATA, 16'($urandom)));
        end
        stim_q.push_back(mk(OP_RD_DATA, 16'($urandom)));
        stim_q.push_back(mk(OP_RD_DATA, 16'($urandom)));
    endfunction

    function automatic void gen_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++)
            stim_q.push_back(mk(4'($urandom_range(0, 15)), 16'($urandom)));
    endfunction

    typedef struct {
        t_item   it;
        bit      typed;
        t_result want;
    } t_row;

    t_row directed [$];

    function automatic t_row row(logic [3:0] op, logic [15:0] bv, logic [7:0] pad, bit typed,
                                 logic [15:0] rd, logic sch, logic can, logic rai);
        t_row r;
        r.it = '{opcode: op, bus_value: bv, pad_reply: pad, preload_card: 1'b1,
                 preload_address: 17'h1ffff};
        r.typed = typed;
        r.want  = '{read_data: rd, irq_schedule: sch, irq_cancel: can, irq_raise: rai};
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side
    initial begin
        t_result got, want;
        int      stall;
        m_axis_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = (results_seen == 150) ? 700 : $urandom_range(0, 18);
            if (burst && results_seen != 150) stall = 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(negedge i_clk); while (!m_axis_tvalid);
            got = '{read_data: m_axis_tdata[15:0], irq_schedule: m_axis_tdata[16],
                    irq_cancel: m_axis_tdata[17], irq_raise: m_axis_tdata[18]};
            @(posedge i_clk);
            if (due_results.size() == 0) begin
                report("unexpected item", got.read_data, 16'd0);
            end else begin
                want = due_results.pop_front();
                if (got.read_data !== want.read_data)
                    report("read_data", got.read_data, want.read_data);
                if (got.irq_schedule !== want.irq_schedule)
                    report("irq_schedule", 16'(got.irq_schedule), 16'(want.irq_schedule));
                if (got.irq_cancel !== want.irq_cancel)
                    report("irq_cancel", 16'(got.irq_cancel), 16'(want.irq_cancel));
                if (got.irq_raise !== want.irq_raise)
                    report("irq_raise", 16'(got.irq_raise), 16'(want.irq_raise));
            end
            results_seen++;
        end
    end

    initial begin
        logic        lm, dis;
        logic [31:0] hdr;
        int          r;
        error_count   = 0;
        results_seen  = 0;
        items_sent    = 0;
        burst         = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        sh_link_mode = 1'b0;
        sh_irq_disable = 1'b0;
        sh_header = 32'hFF085A5D;
        sh_status = ST_TX_RDY | ST_TX_EMPTY;
        sh_mode = '0;
        sh_ctrl = '0;
        sh_baud = '0;
        for (int k = 0; k < 134; k++) sh_reply[k] = '0;
        for (int k = 0; k < 2 * CARD_SIZE; k++) sh_card[k] = '0;
        sh_idx = '0;
        sh_end = '0;
        sh_pad_phase = '0;
        sh_card_phase = '0;
        sh_dir = DIR_NONE;
        sh_frame_hi = '0;
        sh_frame_lo = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apply_cfg(1'b0, 1'b0, 32'hFF085A5D);

        directed.push_back(row(OP_RD_STAT, 16'h0000, 8'h00, 1, 16'h0005, 0, 0, 0));
        directed.push_back(row(OP_RD_MODE, 16'hffff, 8'hff, 1, 16'h0000, 0, 0, 0));
        directed.push_back(row(OP_RD_CTRL, 16'hffff, 8'hff, 1, 16'h0000, 0, 0, 0));
        directed.push_back(row(OP_RD_BAUD, 16'h0000, 8'h00, 1, 16'h0000, 0, 0, 0));
        directed.push_back(row(OP_RD_DATA, 16'hffff, 8'hff, 1, 16'h0000, 0, 0, 0));
        directed.push_back(row(4'd15, 16'hffff, 8'hff, 1, 16'h0000, 0, 0, 0));
        directed.push_back(row(OP_IRQ_DUE, 16'h0000, 8'h00, 1, 16'h0000, 0, 0, 1));
        directed.push_back(row(OP_WR_CTRL, CT_RESET_ERR, 8'h00, 1, 16'h0000, 0, 1, 0));
        directed.push_back(row(OP_WR_MODE, 16'hffff, 8'h00, 1, 16'h0000, 0, 0, 0));
        directed.push_back(row(OP_RD_MODE, 16'h0000, 8'h00, 1, 16'hffff, 0, 0, 0));
        directed.push_back(row(OP_WR_BAUD, 16'hffff, 8'h00, 1, 16'h0000, 0, 0, 0));
        directed.push_back(row(OP_RD_BAUD, 16'h0000, 8'h00, 1, 16'hffff, 0, 0, 0));
        directed.push_back(row(OP_PRELOAD, 16'h00ff, 8'h00, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_WR_CTRL, PORT_ONE, 8'h00, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_WR_DATA, 16'h00ff, 8'h00, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_WR_DATA, {8'hff, PAD_START}, 8'hff, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_WR_DATA, {8'h00, PAD_CMD_43}, PAD_ID_DIG, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_RD_DATA, 16'h0000, 8'h00, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_RD_STAT, 16'h0000, 8'h00, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_WR_CTRL, CT_RESET | PORT_TWO, 8'h00, 1, 16'h0000, 0, 1, 0));
        directed.push_back(row(OP_WR_CTRL, PORT_TWO, 8'h00, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_WR_DATA, {8'h00, CARD_START}, 8'h00, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_WR_DATA, 16'h0099, 8'h00, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_RD_DATA, 16'h0000, 8'h00, 0, 0, 0, 0, 0));
        directed.push_back(row(OP_WR_CTRL, 16'hffff, 8'h00, 0, 0, 0, 0, 0));
        foreach (directed[k]) send_item(directed[k].it, directed[k].typed, directed[k].want);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin lm = 1'b0; dis = 1'b0; hdr = 32'h0000_0000; end
                1: begin lm = 1'b1; dis = 1'b1; hdr = 32'hffff_ffff; end
                2: begin lm = 1'b0; dis = 1'b1; hdr = $urandom; end
                default: begin lm = 1'b1; dis = 1'b0; hdr = 32'hFF085A5D; end
            endcase
            apply_cfg(lm, dis, hdr);
            while (items_sent + stim_q.size() < (ph + 1) * NUM_ITEMS / 4) begin
                r = $urandom_range(0, 9);
                if (r < 3) gen_card();
                else if (r < 8) gen_pad();
                else gen_noise();
            end
            while (stim_q.size() != 0) send_item(stim_q.pop_front(), 1'b0, '0);
            drain();
            if (items_sent >= NUM_ITEMS && ph >= 3) break;
        end

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
